### rtl/ou_state_predictor_defines.svh
// ----------------------------------------------------------------------------
// ou_state_predictor assertion macros
// shared concurrent assertion forms for the predictor rtl
// ----------------------------------------------------------------------------
`ifndef OU_STATE_PREDICTOR_DEFINES_SVH
`define OU_STATE_PREDICTOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define OUSP_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) else $error(msg);

`define OUSP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`define OUSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define OUSP_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)

`define OUSP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)

`define OUSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### rtl/ousp_pkg.sv
// ----------------------------------------------------------------------------
// ousp_pkg
// types, constants and exponential table of the state predictor
// ----------------------------------------------------------------------------
package ousp_pkg;

    localparam int D_W   = 32;   // q16.16 data
    localparam int G_W   = 24;   // q8.16 rate and horizon
    localparam int U_W   = 48;   // q16.32 exponent argument
    localparam int E_W   = 33;   // q0.32 exponential, 1.0 included
    localparam int N_W   = 6;    // integer multiple of ln2
    localparam int Q_W   = 41;   // quotient bits of (1-e)/g
    localparam int E_STEPS = 16;

    localparam logic [E_W-1:0] E_ONE   = 33'h1_0000_0000;
    localparam logic [U_W-1:0] LN2_Q32 = 48'd2977044472;
    localparam logic [U_W-1:0] LN2_X33 = 48'd98242467576;

    // front pipeline stage map
    localparam int FS_IN   = 0;
    localparam int FS_MUL  = 1;
    localparam int FS_N0   = 2;
    localparam int FS_E0   = FS_N0 + N_W;
    localparam int FS_LO   = FS_E0 + E_STEPS;
    localparam int FS_SH   = FS_LO + 1;
    localparam int FS_NUM  = FS_SH + 1;
    localparam int FS_D0   = FS_NUM + 1;
    localparam int FS_AB   = FS_D0 + Q_W;
    localparam int FS_NSTG = FS_AB + 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int OUT_DEPTH   = 2;

    localparam int CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATE_X = 1'b0,
        CFG_RATE_Y = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0][D_W-1:0] pos;
        logic [1:0][D_W-1:0] vel;
        logic [1:0][D_W-1:0] mean;
        logic [G_W-1:0]      t;
    } t_item;

    typedef struct packed {
        logic [1:0][D_W-1:0] pos;
        logic [1:0][D_W-1:0] vel;
        logic [1:0][D_W-1:0] mean;
        logic [1:0][E_W-1:0] e;
        logic [1:0][D_W-1:0] a;
        logic [1:0][D_W-1:0] b;
    } t_coef;

    typedef struct packed {
        logic [1:0][D_W-1:0] new_pos;
        logic [1:0][D_W-1:0] new_vel;
    } t_result;

    // shift-subtract quotient, used only while building the table
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], num[b]};
            if (r >= {1'b0, den}) begin
                r    = r - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // exp(-2^-i) in q0.32, taylor series at q0.60, evaluated at elaboration
    function automatic logic [31:0] exp_neg_pow2(input int i);
        logic [63:0] pos_sum;
        logic [63:0] neg_sum;
        logic [63:0] fact;
        logic [63:0] term;
        logic [63:0] res;
        int          sh;
        pos_sum = '0;
        neg_sum = '0;
        fact    = 64'd1;
        for (int n = 0; n < 16; n++) begin
            sh = i * n;
            if (n > 0) fact = fact * 64'(n);
            if (sh < 60) begin
                term = udiv64(64'd1 << (60 - sh), fact);
                if ((n & 1) == 1) neg_sum = neg_sum + term;
                else              pos_sum = pos_sum + term;
            end
        end
        res = (pos_sum - neg_sum + (64'd1 << 27)) >> 28;
        return res[31:0];
    endfunction

    function automatic logic [E_STEPS:1][31:0] build_exp_tab();
        logic [E_STEPS:1][31:0] tab;
        for (int i = 1; i <= E_STEPS; i++) tab[i] = exp_neg_pow2(i);
        return tab;
    endfunction

    localparam logic [E_STEPS:1][31:0] EXP_TAB = build_exp_tab();

endpackage

### rtl/ou_state_predictor.sv
// ----------------------------------------------------------------------------
// ou_state_predictor
// planar mean-reverting state prediction, queue style channels
// ----------------------------------------------------------------------------
// Input channel: drive the item fields with push high; the transaction is
// taken at a clock edge where push is high and full is low.
// Result channel: while empty is low the oldest prediction is on the o_new_*
// ports; it is removed at a clock edge where pop is high.
// Configuration: i_cfg_we writes i_cfg_wdata to rate register i_cfg_idx at
// the clock edge, no wait states; write only while the block is idle.
// Path of an item: 69 front stages (shift-subtract by ln2, 16 table
// multiplies, a 41 stage pipelined divider), the coefficient queue,
// 4 back stages and the output queue.
// Throughput: one transaction per cycle while full is low, with no dependence between items.
// A stalled receiver fills the output queue, then the back stages and the
// coefficient queue, and only then raises full.
// Reset (synchronous, active low) empties all queues and pipelines and sets
// both rates to 6554.
// ----------------------------------------------------------------------------
module ou_state_predictor #(
    parameter int QUEUE_DEPTH = ousp_pkg::QUEUE_DEPTH,
    parameter int OUT_DEPTH   = ousp_pkg::OUT_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [31:0]                       i_pos_x,
    input  logic [31:0]                       i_pos_y,
    input  logic [31:0]                       i_vel_x,
    input  logic [31:0]                       i_vel_y,
    input  logic [31:0]                       i_mean_vel_x,
    input  logic [31:0]                       i_mean_vel_y,
    input  logic [23:0]                       i_horizon,
    output logic                              empty,
    input  logic                              pop,
    output logic [31:0]                       o_new_pos_x,
    output logic [31:0]                       o_new_pos_y,
    output logic [31:0]                       o_new_vel_x,
    output logic [31:0]                       o_new_vel_y,
    input  logic                              i_cfg_we,
    input  logic [ousp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [23:0]                       i_cfg_wdata
);

    localparam int CW = $bits(ousp_pkg::t_coef);
    localparam int RW = $bits(ousp_pkg::t_result);

    logic [ousp_pkg::G_W-1:0] r_rate_x, r_rate_y;

    ousp_pkg::t_item   w_item;
    ousp_pkg::t_coef   w_fcoef, w_bcoef;
    ousp_pkg::t_result w_bres, w_ores;
    logic [CW-1:0]     w_qdata;
    logic [RW-1:0]     w_odata;
    logic              w_fvld, w_qfull, w_qempty, w_take;
    logic              w_bvld, w_ofull;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_x <= 24'd6554;
            r_rate_y <= 24'd6554;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == ousp_pkg::CFG_RATE_X) r_rate_x <= i_cfg_wdata;
            if (i_cfg_idx == ousp_pkg::CFG_RATE_Y) r_rate_y <= i_cfg_wdata;
        end
    end

    assign w_item.pos  = {i_pos_y, i_pos_x};
    assign w_item.vel  = {i_vel_y, i_vel_x};
    assign w_item.mean = {i_mean_vel_y, i_mean_vel_x};
    assign w_item.t    = i_horizon;

    ousp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (w_item),
        .o_full  (full),
        .i_rate  ({r_rate_y, r_rate_x}),
        .o_vld   (w_fvld),
        .o_coef  (w_fcoef),
        .i_ready (!w_qfull)
    );

    ousp_fifo #(
        .WIDTH (CW),
        .DEPTH (QUEUE_DEPTH)
    ) u_coef_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fvld),
        .i_data  (w_fcoef),
        .o_full  (w_qfull),
        .i_pop   (w_take),
        .o_data  (w_qdata),
        .o_empty (w_qempty)
    );

    assign w_bcoef = ousp_pkg::t_coef'(w_qdata);

    ousp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (!w_qempty),
        .i_coef  (w_bcoef),
        .o_take  (w_take),
        .o_vld   (w_bvld),
        .o_res   (w_bres),
        .i_ready (!w_ofull)
    );

    ousp_fifo #(
        .WIDTH (RW),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_bvld),
        .i_data  (w_bres),
        .o_full  (w_ofull),
        .i_pop   (pop),
        .o_data  (w_odata),
        .o_empty (empty)
    );

    assign w_ores      = ousp_pkg::t_result'(w_odata);
    assign o_new_pos_x = w_ores.new_pos[0];
    assign o_new_pos_y = w_ores.new_pos[1];
    assign o_new_vel_x = w_ores.new_vel[0];
    assign o_new_vel_y = w_ores.new_vel[1];

endmodule

### rtl/ousp_fifo.sv
// ----------------------------------------------------------------------------
// ousp_fifo
// small register queue between pipeline segments
// ----------------------------------------------------------------------------
`include "ou_state_predictor_defines.svh"

module ousp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = ousp_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, n_wr;
    logic [AW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             w_push, w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_push) n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        if (w_pop)  n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        if (w_push && !w_pop)      n_cnt = r_cnt + CW'(1);
        else if (!w_push && w_pop) n_cnt = r_cnt - CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr] <= i_data;
    end

    `OUSP_ASSERT_ALWAYS(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CW'(DEPTH), "fifo count overrun")
    `OUSP_ASSERT_NEXT(a_cnt_up, i_clk, i_rst_n, w_push && !w_pop, r_cnt == $past(r_cnt) + CW'(1), "fifo count lost a write")

endmodule

### rtl/ousp_front.sv
// ----------------------------------------------------------------------------
// ousp_front
// coefficient pipeline: exponential and (1-e)/g per axis
// ----------------------------------------------------------------------------
`include "ou_state_predictor_defines.svh"

module ousp_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_push,
    input  ousp_pkg::t_item                       i_item,
    output logic                                  o_full,
    input  logic [1:0][ousp_pkg::G_W-1:0]         i_rate,
    output logic                                  o_vld,
    output ousp_pkg::t_coef                       o_coef,
    input  logic                                  i_ready
);

    localparam int NSTG = ousp_pkg::FS_NSTG;
    localparam int LAST = NSTG - 1;

    typedef struct packed {
        logic [1:0][ousp_pkg::D_W-1:0] pos;
        logic [1:0][ousp_pkg::D_W-1:0] vel;
        logic [1:0][ousp_pkg::D_W-1:0] mean;
        logic [ousp_pkg::G_W-1:0]      t;
        logic [1:0][ousp_pkg::G_W-1:0] g;
        logic [1:0]                    zero;
        logic [1:0]                    big;
        logic [1:0][ousp_pkg::U_W-1:0] rem;
        logic [1:0][ousp_pkg::N_W-1:0] n;
        logic [1:0][ousp_pkg::E_W-1:0] ex;
        logic [1:0][ousp_pkg::Q_W-1:0] num;
        logic [1:0][ousp_pkg::G_W-1:0] drem;
        logic [1:0][ousp_pkg::Q_W-1:0] q;
        logic [1:0][ousp_pkg::D_W-1:0] a;
        logic [1:0][ousp_pkg::D_W-1:0] b;
    } t_fstage;

    t_fstage          r_stg [NSTG];
    t_fstage          n_stg [NSTG];
    logic [NSTG-1:0]  r_vld;
    logic             w_en;

    // whole segment moves together unless the tail is held by the queue
    assign w_en   = !r_vld[LAST] || i_ready;
    assign o_full = !w_en;
    assign o_vld  = r_vld[LAST];

    for (genvar s = 0; s < NSTG; s++) begin : g_stg
        if (s == ousp_pkg::FS_IN) begin : g_in
            always_comb begin
                n_stg[s]      = '0;
                n_stg[s].pos  = i_item.pos;
                n_stg[s].vel  = i_item.vel;
                n_stg[s].mean = i_item.mean;
                n_stg[s].t    = i_item.t;
                for (int ax = 0; ax < 2; ax++) begin
                    n_stg[s].g[ax]    = i_rate[ax];
                    n_stg[s].zero[ax] = (i_rate[ax] == '0);
                    n_stg[s].ex[ax]   = ousp_pkg::E_ONE;
                end
            end
        end else if (s == ousp_pkg::FS_MUL) begin : g_mul
            always_comb begin
                n_stg[s] = r_stg[s-1];
                for (int ax = 0; ax < 2; ax++) begin
                    n_stg[s].rem[ax] = ousp_pkg::U_W'(r_stg[s-1].t) *
                                       ousp_pkg::U_W'(r_stg[s-1].g[ax]);
                end
            end
        end else if (s < ousp_pkg::FS_E0) begin : g_nstep
            // restoring division by ln2, one quotient bit per stage
            localparam int K = ousp_pkg::FS_E0 - 1 - s;
            always_comb begin
                logic [ousp_pkg::U_W-1:0] sub;
                n_stg[s] = r_stg[s-1];
                sub = ousp_pkg::LN2_Q32 << K;
                for (int ax = 0; ax < 2; ax++) begin
                    if (s == ousp_pkg::FS_N0)
                        n_stg[s].big[ax] = (r_stg[s-1].rem[ax] >= ousp_pkg::LN2_X33);
                    if (r_stg[s-1].rem[ax] >= sub) begin
                        n_stg[s].rem[ax]  = r_stg[s-1].rem[ax] - sub;
                        n_stg[s].n[ax][K] = 1'b1;
                    end
                end
            end
        end else if (s < ousp_pkg::FS_LO) begin : g_estep
            localparam int I = s - ousp_pkg::FS_E0 + 1;
            always_comb begin
                logic [65:0] prod;
                n_stg[s] = r_stg[s-1];
                for (int ax = 0; ax < 2; ax++) begin
                    prod = 66'(r_stg[s-1].ex[ax]) * 66'(ousp_pkg::EXP_TAB[I]) +
                           (66'(1) << 31);
                    if (r_stg[s-1].rem[ax][32-I])
                        n_stg[s].ex[ax] = ousp_pkg::E_W'(prod >> 32);
                end
            end
        end else if (s == ousp_pkg::FS_LO) begin : g_lo
            // remaining low fraction bits by first order correction
            always_comb begin
                logic [49:0] prod;
                n_stg[s] = r_stg[s-1];
                for (int ax = 0; ax < 2; ax++) begin
                    prod = 50'(r_stg[s-1].ex[ax]) * 50'(r_stg[s-1].rem[ax][15:0]) +
                           (50'(1) << 31);
                    n_stg[s].ex[ax] = r_stg[s-1].ex[ax] - ousp_pkg::E_W'(prod >> 32);
                end
            end
        end else if (s == ousp_pkg::FS_SH) begin : g_sh
            always_comb begin
                logic [33:0] rnd;
                logic [33:0] sum;
                n_stg[s] = r_stg[s-1];
                for (int ax = 0; ax < 2; ax++) begin
                    rnd = (34'(1) << r_stg[s-1].n[ax]) >> 1;
                    sum = (34'(r_stg[s-1].ex[ax]) + rnd) >> r_stg[s-1].n[ax];
                    if (r_stg[s-1].zero[ax])     n_stg[s].ex[ax] = ousp_pkg::E_ONE;
                    else if (r_stg[s-1].big[ax]) n_stg[s].ex[ax] = '0;
                    else                         n_stg[s].ex[ax] = ousp_pkg::E_W'(sum);
                end
            end
        end else if (s == ousp_pkg::FS_NUM) begin : g_num
            always_comb begin
                n_stg[s] = r_stg[s-1];
                for (int ax = 0; ax < 2; ax++) begin
                    n_stg[s].num[ax]  = (ousp_pkg::Q_W'(ousp_pkg::E_ONE - r_stg[s-1].ex[ax]) << 8)
                                        + ousp_pkg::Q_W'(r_stg[s-1].g[ax] >> 1);
                    n_stg[s].drem[ax] = '0;
                    n_stg[s].q[ax]    = '0;
                end
            end
        end else if (s < ousp_pkg::FS_AB) begin : g_div
            localparam int J = ousp_pkg::Q_W - 1 - (s - ousp_pkg::FS_D0);
            always_comb begin
                logic [ousp_pkg::G_W:0] tmp;
                n_stg[s] = r_stg[s-1];
                for (int ax = 0; ax < 2; ax++) begin
                    tmp = {r_stg[s-1].drem[ax], r_stg[s-1].num[ax][J]};
                    if (tmp >= {1'b0, r_stg[s-1].g[ax]}) begin
                        n_stg[s].drem[ax] = ousp_pkg::G_W'(tmp - {1'b0, r_stg[s-1].g[ax]});
                        n_stg[s].q[ax][J] = 1'b1;
                    end else begin
                        n_stg[s].drem[ax] = tmp[ousp_pkg::G_W-1:0];
                    end
                end
            end
        end else begin : g_ab
            always_comb begin
                logic [ousp_pkg::D_W-1:0] t24;
                n_stg[s] = r_stg[s-1];
                t24 = {r_stg[s-1].t, 8'b0};
                for (int ax = 0; ax < 2; ax++) begin
                    if (r_stg[s-1].zero[ax] || r_stg[s-1].q[ax] > ousp_pkg::Q_W'(t24))
                        n_stg[s].a[ax] = t24;
                    else
                        n_stg[s].a[ax] = r_stg[s-1].q[ax][ousp_pkg::D_W-1:0];
                    n_stg[s].b[ax] = t24 - n_stg[s].a[ax];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_push};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int s = 0; s < NSTG; s++) r_stg[s] <= n_stg[s];
        end
    end

    assign o_coef.pos  = r_stg[LAST].pos;
    assign o_coef.vel  = r_stg[LAST].vel;
    assign o_coef.mean = r_stg[LAST].mean;
    assign o_coef.e    = r_stg[LAST].ex;
    assign o_coef.a    = r_stg[LAST].a;
    assign o_coef.b    = r_stg[LAST].b;

    `OUSP_ASSERT_NEXT(a_tail_hold, i_clk, i_rst_n, r_vld[LAST] && !i_ready, r_vld[LAST] && $stable(r_stg[LAST]), "held transaction left the front tail")
    `OUSP_ASSERT_IMPLY(a_a_le_t, i_clk, i_rst_n, r_vld[LAST], r_stg[LAST].a[0] <= (32'(r_stg[LAST].t) << 8) && r_stg[LAST].a[1] <= (32'(r_stg[LAST].t) << 8), "position gain exceeds horizon")

endmodule

### rtl/ousp_back.sv
// ----------------------------------------------------------------------------
// ousp_back
// product, sum and saturation pipeline of the predicted state
// ----------------------------------------------------------------------------
module ousp_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_vld,
    input  ousp_pkg::t_coef       i_coef,
    output logic                  o_take,
    output logic                  o_vld,
    output ousp_pkg::t_result     o_res,
    input  logic                  i_ready
);

    localparam int P_W = 58;   // position sum, q.32
    localparam int V_W = 50;   // velocity sum, q.32

    typedef struct packed {
        logic [1:0]                    sv;
        logic [1:0]                    sm;
        logic [1:0][ousp_pkg::D_W-1:0] pos;
        logic [1:0][63:0]              pav;
        logic [1:0][63:0]              pbm;
        logic [1:0][63:0]              pev;
        logic [1:0][63:0]              pom;
    } t_bmul;

    typedef struct packed {
        logic [1:0][ousp_pkg::D_W-1:0] pos;
        logic [1:0][P_W-1:0]           tav;
        logic [1:0][P_W-1:0]           tbm;
        logic [1:0][V_W-1:0]           tev;
        logic [1:0][V_W-1:0]           tom;
    } t_bterm;

    typedef struct packed {
        logic [1:0][P_W-1:0] p;
        logic [1:0][V_W-1:0] v;
    } t_bsum;

    t_bmul             r_mul, n_mul;
    t_bterm            r_term, n_term;
    t_bsum             r_sum, n_sum;
    ousp_pkg::t_result r_res, n_res;
    logic [3:0]        r_vld;
    logic              w_en;

    function automatic logic [31:0] sat_q16(input logic [P_W-1:0] v);
        logic [P_W-1:0] mag;
        logic [P_W-1:0] m;
        logic [31:0]    res;
        mag = v[P_W-1] ? (P_W'(0) - v) : v;
        m   = (mag + P_W'(16'h8000)) >> 16;
        if (v[P_W-1]) res = (m > P_W'(33'h0_8000_0000)) ? 32'h8000_0000 : 32'(0) - m[31:0];
        else          res = (m > P_W'(32'h7fff_ffff)) ? 32'h7fff_ffff : m[31:0];
        return res;
    endfunction

    assign w_en   = !r_vld[3] || i_ready;
    assign o_take = w_en && i_vld;
    assign o_vld  = r_vld[3];
    assign o_res  = r_res;

    always_comb begin
        logic [31:0]          mv;
        logic [31:0]          mm;
        logic [ousp_pkg::E_W-1:0] om;
        for (int ax = 0; ax < 2; ax++) begin
            mv = i_coef.vel[ax][31]  ? 32'(0) - i_coef.vel[ax]  : i_coef.vel[ax];
            mm = i_coef.mean[ax][31] ? 32'(0) - i_coef.mean[ax] : i_coef.mean[ax];
            om = ousp_pkg::E_ONE - i_coef.e[ax];
            n_mul.sv[ax]  = i_coef.vel[ax][31];
            n_mul.sm[ax]  = i_coef.mean[ax][31];
            n_mul.pos[ax] = i_coef.pos[ax];
            n_mul.pav[ax] = 64'(i_coef.a[ax]) * 64'(mv);
            n_mul.pbm[ax] = 64'(i_coef.b[ax]) * 64'(mm);
            n_mul.pev[ax] = 64'(i_coef.e[ax]) * 64'(mv);
            n_mul.pom[ax] = 64'(om) * 64'(mm);
        end
    end

    // each product rounded half away from zero before the sums
    always_comb begin
        logic [63:0] r1, r2, r3, r4;
        for (int ax = 0; ax < 2; ax++) begin
            r1 = (r_mul.pav[ax] + 64'd128) >> 8;
            r2 = (r_mul.pbm[ax] + 64'd128) >> 8;
            r3 = (r_mul.pev[ax] + 64'd32768) >> 16;
            r4 = (r_mul.pom[ax] + 64'd32768) >> 16;
            n_term.pos[ax] = r_mul.pos[ax];
            n_term.tav[ax] = r_mul.sv[ax] ? P_W'(0) - P_W'(r1) : P_W'(r1);
            n_term.tbm[ax] = r_mul.sm[ax] ? P_W'(0) - P_W'(r2) : P_W'(r2);
            n_term.tev[ax] = r_mul.sv[ax] ? V_W'(0) - V_W'(r3) : V_W'(r3);
            n_term.tom[ax] = r_mul.sm[ax] ? V_W'(0) - V_W'(r4) : V_W'(r4);
        end
    end

    always_comb begin
        for (int ax = 0; ax < 2; ax++) begin
            n_sum.p[ax] = {{(P_W-48){r_term.pos[ax][31]}}, r_term.pos[ax], 16'b0}
                          + r_term.tav[ax] + r_term.tbm[ax];
            n_sum.v[ax] = r_term.tev[ax] + r_term.tom[ax];
        end
    end

    always_comb begin
        for (int ax = 0; ax < 2; ax++) begin
            n_res.new_pos[ax] = sat_q16(r_sum.p[ax]);
            n_res.new_vel[ax] = sat_q16(P_W'($signed(r_sum.v[ax])));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mul  <= n_mul;
            r_term <= n_term;
            r_sum  <= n_sum;
            r_res  <= n_res;
        end
    end

endmodule
